### rtl/tdpr_pkg.sv
package tdpr_pkg;

  localparam int NUM_STATES  = 4;
  localparam int NUM_SYMBOLS = 4;

  localparam int NUM_REGS = 8;
  localparam int REG_W    = 52;
  localparam int REG_IW   = $clog2(NUM_REGS);
  localparam int ENTRY_W  = 6;

  // Register holding the initial state and the initial stack symbol.
  localparam logic [REG_IW-1:0] REG_INIT = REG_IW'(1);

  localparam int ACC_BIT        = 48;
  localparam int INIT_STATE_LSB = 48;
  localparam int INIT_SYM_LSB   = 50;

  localparam int QUEUE_DEPTH = 4;
  localparam int QAW         = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    CAUSE_OK       = 2'd0,
    CAUSE_NO_TRANS = 2'd1,
    CAUSE_OVERFLOW = 2'd2,
    CAUSE_NOT_ACC  = 2'd3
  } cause_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] next_state;
    logic       pop;
    logic [1:0] push;
  } entry_t;

  // One classified input item as it travels from the front end to the engine.
  typedef struct packed {
    logic [1:0] sym;
    logic       has_sym;
    logic       sym_ok;
    logic       last;
  } item_t;

endpackage

### rtl/tdpr_front.sv
module tdpr_front import tdpr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tuser,
  input  logic       in_tlast,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_pop
);

  item_t          fifo_r [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW:0]   count_r;
  logic           push;
  logic           pop;
  item_t          item_in;

  always_comb begin
    item_in.sym     = in_tdata[1:0];
    item_in.has_sym = in_tuser;
    item_in.sym_ok  = int'(in_tdata[1:0]) < NUM_SYMBOLS;
    item_in.last    = in_tlast;
  end

  assign in_tready = count_r != (QAW+1)'(QUEUE_DEPTH);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = count_r != '0;
  assign pop       = q_pop && q_valid;
  assign q_item    = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (QAW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (QAW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

### rtl/tdpr_back.sv
module tdpr_back import tdpr_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [REG_IW-1:0] cfg_index,
  input  logic [REG_W-1:0]  cfg_wdata,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic [REG_W-1:0] regs_r [NUM_REGS];
  logic [1:0]       mem [STACK_DEPTH];

  // Stack entries 0 (bottom), count-1 (top) and count-2 (below) are cached in
  // registers; the rest live in the memory. The below entry comes from the
  // registered memory read for one item after a plain pop.
  logic          in_str_r;
  logic [1:0]    state_r;
  logic [CW-1:0] cnt_r;
  logic [1:0]    top_r;
  logic [1:0]    below_r;
  logic [1:0]    bot_r;
  cause_t        rej_r;
  logic          below_mem_r;
  logic [1:0]    rd_data_r;
  logic          out_valid_r;
  logic          out_acc_r;
  cause_t        out_cause_r;

  logic [1:0]    init_state;
  logic [1:0]    init_sym;
  logic [1:0]    st_cur;
  logic [CW-1:0] cnt_cur;
  logic [1:0]    top_cur;
  logic [1:0]    below_cur;
  logic [1:0]    bot_cur;
  cause_t        rej_cur;

  logic [REG_W-1:0] trow;
  logic [2:0]       k;
  entry_t           e;
  logic             hit;
  logic             pop_eff;
  logic             fire;

  logic [1:0]    st_nxt;
  logic [CW-1:0] cnt_nxt;
  logic [1:0]    top_nxt;
  logic [1:0]    below_nxt;
  logic [1:0]    bot_nxt;
  cause_t        rej_nxt;
  logic          below_mem_nxt;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [CW-1:0] wr_idx;
  logic [CW-1:0] idx3;
  logic          acc;
  cause_t        cause;

  assign init_state = regs_r[REG_INIT][INIT_STATE_LSB +: 2];
  assign init_sym   = regs_r[REG_INIT][INIT_SYM_LSB +: 2];

  // The first item of a string sees the freshly initialized stack.
  always_comb begin
    if (in_str_r) begin
      st_cur    = state_r;
      cnt_cur   = cnt_r;
      top_cur   = top_r;
      below_cur = below_mem_r ? rd_data_r : below_r;
      bot_cur   = bot_r;
      rej_cur   = rej_r;
    end else begin
      st_cur    = init_state;
      cnt_cur   = CW'(init_sym != 2'd0);
      top_cur   = init_sym;
      below_cur = 2'd0;
      bot_cur   = init_sym;
      rej_cur   = CAUSE_OK;
    end
  end

  assign fire  = q_valid && (!q_item.last || !out_valid_r || out_tready);
  assign q_pop = fire;

  always_comb begin
    int base;
    base    = 0;
    trow    = regs_r[{st_cur, q_item.sym[1]}];
    k       = {q_item.sym[0], top_cur};
    base    = int'(k) * ENTRY_W;
    e       = entry_t'(trow[base +: ENTRY_W]);
    hit     = q_item.sym_ok && (int'(st_cur) < NUM_STATES) && e.valid &&
              (int'(e.next_state) < NUM_STATES);
    pop_eff = e.pop && (cnt_cur != '0);
  end

  always_comb begin
    st_nxt        = st_cur;
    cnt_nxt       = cnt_cur;
    top_nxt       = top_cur;
    below_nxt     = below_cur;
    bot_nxt       = bot_cur;
    rej_nxt       = rej_cur;
    below_mem_nxt = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_idx        = '0;
    idx3          = cnt_cur - CW'(3);
    if (q_item.has_sym && rej_cur == CAUSE_OK) begin
      if (!hit) begin
        rej_nxt = CAUSE_NO_TRANS;
      end else begin
        st_nxt = e.next_state;
        if (pop_eff && e.push != 2'd0) begin
          // Replace the top in place.
          wr_en   = 1'b1;
          wr_idx  = cnt_cur - CW'(1);
          top_nxt = e.push;
        end else if (e.push != 2'd0 && cnt_cur != CW'(STACK_DEPTH)) begin
          wr_en     = 1'b1;
          wr_idx    = cnt_cur;
          top_nxt   = e.push;
          below_nxt = top_cur;
          cnt_nxt   = cnt_cur + CW'(1);
        end else if (e.push != 2'd0) begin
          rej_nxt = CAUSE_OVERFLOW;
        end else if (pop_eff) begin
          cnt_nxt = cnt_cur - CW'(1);
          top_nxt = below_cur;
          if (cnt_cur == CW'(3)) begin
            below_nxt = bot_cur;
          end else if (cnt_cur > CW'(3)) begin
            below_mem_nxt = 1'b1;
            rd_addr       = idx3[AW-1:0];
          end else begin
            below_nxt = 2'd0;
          end
        end
      end
    end
    if (wr_en && wr_idx == '0) begin
      bot_nxt = e.push;
    end
  end

  always_comb begin
    acc = ((int'(st_nxt) < NUM_STATES) && regs_r[{st_nxt, 1'b0}][ACC_BIT]) ||
          (init_sym != 2'd0 && cnt_nxt == CW'(1) && bot_nxt == init_sym);
    if (rej_nxt != CAUSE_OK) begin
      cause = rej_nxt;
    end else if (acc) begin
      cause = CAUSE_OK;
    end else begin
      cause = CAUSE_NOT_ACC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '{default: '0};
    end else if (cfg_we) begin
      regs_r[cfg_index] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_str_r    <= 1'b0;
      state_r     <= '0;
      cnt_r       <= '0;
      top_r       <= '0;
      below_r     <= '0;
      bot_r       <= '0;
      rej_r       <= CAUSE_OK;
      below_mem_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        in_str_r    <= !q_item.last;
        state_r     <= st_nxt;
        cnt_r       <= cnt_nxt;
        top_r       <= top_nxt;
        below_r     <= below_nxt;
        bot_r       <= bot_nxt;
        rej_r       <= rej_nxt;
        below_mem_r <= below_mem_nxt;
      end
      if (fire && q_item.last) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && q_item.last) begin
      out_acc_r   <= (rej_nxt == CAUSE_OK) && acc;
      out_cause_r <= cause;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && wr_en && wr_idx != '0) begin
      mem[wr_idx[AW-1:0]] <= e.push;
    end
    if (fire) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_cause_r, out_acc_r};

endmodule

### rtl/table_driven_pushdown_recognizer.sv
// Channel   Dir  Handshake             Payload
// in_       in   in_tvalid/in_tready   tdata: symbol; tuser: has_symbol; tlast: last
// out_      out  out_tvalid/out_tready tdata: accepted, cause
// cfg_      in   cfg_we                cfg_index selects one of eight table registers
//
// One item per cycle sustained unless a verdict stalls the engine; the last item
// of a string passes the input queue, and its verdict is held in the output register.
// The stack step works on cached top, below and bottom entries, with the stack
// memory read registered after a pop for use by the next item.
// A four-entry queue decouples intake from the engine; the engine stalls only
// when a verdict meets a full, unread output register.
// Reset is synchronous, active low, and needs no clearing pass.
module table_driven_pushdown_recognizer import tdpr_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [REG_IW-1:0] cfg_index,
  input  logic [REG_W-1:0]  cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [1:0] symbol
  input  logic              in_tuser,   // [0] has_symbol
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata   // [0] accepted, [2:1] cause
);

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  tdpr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  tdpr_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### rtl/tdpr_checker.sv
module tdpr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // Strings closed at the input whose verdict has not been transferred yet.
  logic [3:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 4'(in_tvalid && in_tready && in_tlast) -
                4'(out_tvalid && out_tready);
    end
  end

  // A stalled verdict holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled verdict changed");

  // The accept flag and the cause code must agree.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[2:1] == 2'd0)))
    else $error("accept flag and cause disagree");

  // Padding bits of the verdict stay zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:3] == 5'd0)
    else $error("verdict padding not zero");

  // No verdict is shown right after reset.
  assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("verdict valid after reset");

  // A verdict can only stand for a string whose closing transfer was taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != 4'd0)
    else $error("verdict without a closing transfer");

endmodule

bind table_driven_pushdown_recognizer tdpr_checker u_tdpr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tdpr_pkg::*;

  localparam int STACK_DEPTH = 64;
  localparam int STALL_LIMIT = 2000;

  // Input symbols and stack symbols of the counting table (a^n b^n with extras).
  localparam logic [1:0] SYM_A    = 2'd0;
  localparam logic [1:0] SYM_B    = 2'd1;
  localparam logic [1:0] SYM_POP  = 2'd2;
  localparam logic [1:0] SYM_SWAP = 2'd3;
  localparam logic [1:0] STK_NONE = 2'd0;
  localparam logic [1:0] STK_Z    = 2'd1;
  localparam logic [1:0] STK_A    = 2'd2;
  localparam logic [1:0] STK_B    = 2'd3;
  localparam logic [1:0] ST_COUNT = 2'd0;
  localparam logic [1:0] ST_MATCH = 2'd1;
  localparam logic [1:0] ST_ALT   = 2'd2;

  typedef struct {
    logic [1:0] sym;
    logic       has_sym;
    logic       last;
  } symbol_item_t;

  typedef struct {
    logic   accepted;
    cause_t cause;
  } verdict_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              cfg_we     = 1'b0;
  logic [REG_IW-1:0] cfg_index  = '0;
  logic [REG_W-1:0]  cfg_wdata  = '0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata   = '0;   // [1:0] symbol
  logic              in_tuser   = 1'b0; // [0] has_symbol
  logic              in_tlast   = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;         // [0] accepted, [2:1] cause

  table_driven_pushdown_recognizer #(.STACK_DEPTH(STACK_DEPTH)) uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Recognizer shadow state.
  logic [REG_W-1:0] table_copy [NUM_REGS];
  logic [REG_W-1:0] plan [NUM_REGS];
  logic [1:0]       stack_copy [STACK_DEPTH];
  int               stack_len;
  logic [1:0]       top_copy;
  logic [1:0]       state_copy;
  cause_t           cause_copy;
  bit               in_string;

  symbol_item_t symbol_queue [$];
  verdict_t     verdict_queue [$];
  int           outstanding;
  int           errors;

  function automatic logic [1:0] init_symbol();
    return table_copy[REG_INIT][INIT_SYM_LSB +: 2];
  endfunction

  function automatic void recognize(symbol_item_t it);
    int       ri;
    int       k;
    entry_t   move;
    verdict_t v;
    if (!in_string) begin
      state_copy = table_copy[REG_INIT][INIT_STATE_LSB +: 2];
      top_copy   = init_symbol();
      cause_copy = CAUSE_OK;
      stack_len  = 0;
      if (top_copy != STK_NONE) begin
        stack_copy[0] = top_copy;
        stack_len     = 1;
      end
      in_string = 1'b1;
    end
    if (it.has_sym && cause_copy == CAUSE_OK) begin
      ri   = 2 * int'(state_copy) + int'(it.sym[1]);
      k    = 4 * int'(it.sym[0]) + int'(top_copy);
      move = table_copy[ri][ENTRY_W*k +: ENTRY_W];
      if (!move.valid) begin
        cause_copy = CAUSE_NO_TRANS;
      end else begin
        if (move.pop && stack_len > 0) stack_len--;
        if (move.push != STK_NONE) begin
          // The pop and the state change still take effect on an overflow.
          if (stack_len >= STACK_DEPTH) begin
            cause_copy = CAUSE_OVERFLOW;
          end else begin
            stack_copy[stack_len] = move.push;
            stack_len++;
          end
        end
        top_copy   = (stack_len == 0) ? STK_NONE : stack_copy[stack_len-1];
        state_copy = move.next_state;
      end
    end
    if (it.last) begin
      if (cause_copy != CAUSE_OK) begin
        v.accepted = 1'b0;
        v.cause    = cause_copy;
      end else begin
        v.accepted = table_copy[2*int'(state_copy)][ACC_BIT] ||
                     (init_symbol() != STK_NONE && stack_len == 1 &&
                      stack_copy[0] == init_symbol());
        v.cause    = v.accepted ? CAUSE_OK : CAUSE_NOT_ACC;
      end
      verdict_queue.push_back(v);
      in_string = 1'b0;
    end
  endfunction

  function automatic void add_item(logic [1:0] sym, logic has_sym, logic last);
    symbol_item_t it;
    it.sym     = sym;
    it.has_sym = has_sym;
    it.last    = last;
    symbol_queue.push_back(it);
    outstanding++;
  endfunction

  function automatic void set_move(logic [1:0] st, logic [1:0] sym, logic [1:0] top,
                                   logic [1:0] nxt, logic pop, logic [1:0] push);
    entry_t e;
    e = '{valid: 1'b1, next_state: nxt, pop: pop, push: push};
    plan[2*int'(st) + int'(sym[1])][ENTRY_W*(4*int'(sym[0]) + int'(top)) +: ENTRY_W] = e;
  endfunction

  function automatic void build_counting_plan();
    foreach (plan[i]) plan[i] = '0;
    set_move(ST_COUNT, SYM_A, STK_Z, ST_COUNT, 1'b0, STK_A);
    set_move(ST_COUNT, SYM_A, STK_A, ST_COUNT, 1'b0, STK_A);
    set_move(ST_COUNT, SYM_B, STK_A, ST_MATCH, 1'b1, STK_NONE);
    for (int t = 0; t < 4; t++) set_move(ST_COUNT, SYM_POP, 2'(t), ST_COUNT, 1'b1, STK_NONE);
    set_move(ST_COUNT, SYM_SWAP, STK_NONE, ST_COUNT, 1'b0, STK_Z);
    set_move(ST_COUNT, SYM_SWAP, STK_A, ST_ALT, 1'b1, STK_B);
    set_move(ST_MATCH, SYM_B, STK_A, ST_MATCH, 1'b1, STK_NONE);
    set_move(ST_ALT, SYM_A, STK_B, ST_ALT, 1'b0, STK_B);
    set_move(ST_ALT, SYM_B, STK_B, ST_ALT, 1'b1, STK_NONE);
    plan[2*int'(ST_ALT)][ACC_BIT] = 1'b1;
    plan[REG_INIT][INIT_STATE_LSB +: 2] = ST_COUNT;
    plan[REG_INIT][INIT_SYM_LSB +: 2]   = STK_Z;
  endfunction

  function automatic void build_random_plan();
    foreach (plan[i]) begin
      plan[i] = REG_W'({$urandom, $urandom});
      // Mostly valid moves so that strings get past the first few symbols.
      for (int k = 0; k < 8; k++)
        if ($urandom_range(0, 7) != 0) plan[i][ENTRY_W*k + ENTRY_W - 1] = 1'b1;
    end
  endfunction

  // a^n b^m strings, sometimes long enough to overflow the stack, with some noise.
  function automatic void add_counted_string();
    logic [1:0] syms [$];
    int         n;
    int         m;
    bit         tail;
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(62, 72) : $urandom_range(0, 8);
    m = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n + 1) : n;
    for (int i = 0; i < n; i++) syms.push_back(SYM_A);
    for (int i = 0; i < m; i++) syms.push_back(SYM_B);
    if (syms.size() != 0 && $urandom_range(0, 4) == 0)
      syms[$urandom_range(0, syms.size() - 1)] = 2'($urandom_range(0, 3));
    tail = ($urandom_range(0, 3) == 0) || (syms.size() == 0);
    foreach (syms[i]) begin
      if ($urandom_range(0, 9) == 0) add_item(2'($urandom_range(0, 3)), 1'b0, 1'b0);
      add_item(syms[i], 1'b1, !tail && i == syms.size() - 1);
    end
    if (tail) add_item(2'($urandom_range(0, 3)), 1'b0, 1'b1);
  endfunction

  function automatic void add_random_string();
    int len;
    bit tail;
    len  = $urandom_range(0, 12);
    tail = ($urandom_range(0, 3) == 0) || (len == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) add_item(2'($urandom_range(0, 3)), 1'b0, 1'b0);
      add_item(2'($urandom_range(0, 3)), 1'b1, !tail && i == len - 1);
    end
    if (tail) add_item(2'($urandom_range(0, 3)), 1'b0, 1'b1);
  endfunction

  task automatic load_plan();
    for (int i = 0; i < NUM_REGS; i++) begin
      @(posedge clk);
      cfg_we        <= 1'b1;
      cfg_index     <= REG_IW'(i);
      cfg_wdata     <= plan[i];
      table_copy[i] = plan[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until every item is taken and every verdict is back, then let the
  // input queue of the block settle before the table may change.
  task automatic drain();
    while (outstanding != 0 || verdict_queue.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Sender.
  int           send_gap    = 0;
  bit           send_steady = 1'b0;
  symbol_item_t next_item;
  symbol_item_t taken_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        taken_item.sym     = in_tdata[1:0];
        taken_item.has_sym = in_tuser;
        taken_item.last    = in_tlast;
        recognize(taken_item);
        outstanding--;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (symbol_queue.size() != 0) begin
          next_item = symbol_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {6'd0, next_item.sym};
          in_tuser  <= next_item.has_sym;
          in_tlast  <= next_item.last;
          if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
          send_gap = send_steady ? 0 : $urandom_range(0, 9);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker.
  int       recv_gap    = 0;
  bit       recv_steady = 1'b0;
  verdict_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (verdict_queue.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected verdict transfer, tdata %h", out_tdata);
        end else begin
          want = verdict_queue.pop_front();
          if (out_tdata[0] !== want.accepted || out_tdata[2:1] !== want.cause) begin
            errors++;
            if (errors <= 10)
              $display("verdict mismatch: accepted %b cause %0d, got accepted %b cause %0d",
                       want.accepted, want.cause, out_tdata[0], out_tdata[2:1]);
          end
        end
        if ($urandom_range(0, 39) == 0) recv_steady = !recv_steady;
        recv_gap = recv_steady ? 0 : $urandom_range(0, 9);
      end else if (recv_gap > 0) begin
        recv_gap--;
      end
      out_tready <= (recv_gap == 0);
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("[table_driven_pushdown_recognizer] ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    foreach (table_copy[i]) table_copy[i] = '0;
    outstanding = 0;
    errors      = 0;
    in_string   = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Table as left by reset: empty stack, nothing accepts, every lookup misses.
    add_item(2'd0, 1'b0, 1'b1);
    add_item(2'd3, 1'b1, 1'b1);
    drain();

    build_counting_plan();
    load_plan();
    add_item(SYM_A, 1'b0, 1'b1);                   // empty string, bottom only
    add_item(SYM_A, 1'b1, 1'b0);
    add_item(SYM_B, 1'b1, 1'b1);
    add_item(SYM_A, 1'b1, 1'b0);
    add_item(SYM_A, 1'b1, 1'b0);
    add_item(SYM_B, 1'b1, 1'b1);                   // ends with A left on the stack
    add_item(SYM_B, 1'b1, 1'b0);                   // miss, later symbols ignored
    add_item(SYM_A, 1'b1, 1'b0);
    add_item(SYM_SWAP, 1'b0, 1'b1);
    add_item(SYM_POP, 1'b1, 1'b0);                 // pops the bottom symbol
    add_item(SYM_POP, 1'b1, 1'b0);                 // pop on an empty stack
    add_item(SYM_SWAP, 1'b1, 1'b0);                // pushes the bottom back
    add_item(SYM_B, 1'b0, 1'b1);
    add_item(SYM_A, 1'b1, 1'b0);
    add_item(SYM_SWAP, 1'b1, 1'b0);                // pop and push in one move
    add_item(SYM_A, 1'b1, 1'b1);                   // accepted by state flag
    drain();

    foreach (plan[i]) plan[i] = '1;
    load_plan();
    add_item(2'd0, 1'b1, 1'b0);
    add_item(2'd3, 1'b1, 1'b0);
    add_item(2'd2, 1'b1, 1'b1);
    drain();

    foreach (plan[i]) plan[i] = '0;
    load_plan();
    add_item(2'd1, 1'b1, 1'b1);
    drain();

    build_counting_plan();
    load_plan();
    while (outstanding < 800) add_counted_string();
    drain();

    repeat (6) begin
      build_random_plan();
      load_plan();
      while (outstanding < 150) add_random_string();
      drain();
    end

    foreach (plan[i]) plan[i] = '1;
    load_plan();
    while (outstanding < 150) add_random_string();
    drain();

    if (errors == 0) begin
      $display("[table_driven_pushdown_recognizer] OK");
    end else begin
      $display("[table_driven_pushdown_recognizer] ERROR");
    end
    $finish;
  end

endmodule
